/* rtl/chs_pkg.sv */
// Shared types and constants of the class histogram share block.
package chs_pkg;

    localparam int TYPE_W     = 16;
    localparam int PIX_W      = 24;
    localparam int CNT_W      = 32;
    localparam int SHARE_W    = 14;
    localparam int KIND_W     = 2;
    localparam int TOPC_W     = 4;
    localparam int ENTRY_W    = TYPE_W + CNT_W;
    localparam int PROD_W     = CNT_W + SHARE_W;
    localparam int FULL_SHARE = 10000;
    localparam logic [TOPC_W-1:0] TOPC_RESET = 4'd5;

    // Result kinds carried on the output user field.
    localparam logic [KIND_W-1:0] KIND_RANKED = 2'd0;
    localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_REST   = 2'd2;

    // Input kinds.
    localparam logic KIND_IN_ADD    = 1'b0;
    localparam logic KIND_IN_REPORT = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RD,
        ST_ADD_CMP,
        ST_ADD_NEW,
        ST_SORT_I,
        ST_SORT_LDI,
        ST_SORT_J,
        ST_SORT_CMP,
        ST_REST_RD,
        ST_REST_ADD,
        ST_EMIT,
        ST_EMIT_DAT,
        ST_DIV,
        ST_OUT
    } t_state;

    // Source of the table write data.
    typedef enum logic [1:0] {
        WR_MERGE,
        WR_NEW,
        WR_CUR
    } t_wr_sel;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic              in_load;
        logic              add_total;
        logic              ram_rd;
        logic              ram_wr;
        t_wr_sel           wr_sel;
        logic              cur_load;
        logic              rest_clr;
        logic              rest_add;
        logic              div_start;
        logic              div_rest;
        logic              slot_empty;
        logic              out_load;
        logic              report_end;
        logic              set_ovf;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic type_match;
        logic count_gt;
        logic div_ok;
        logic out_free;
    } t_sts;

endpackage

/* rtl/chs_ram.sv */
// Generic single write port RAM with a registered read port.
module chs_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/chs_ctrl.sv */
// Controller of the class histogram share block: sequencer, table fill and loop counters.
module chs_ctrl #(
    parameter int TABLE_DEPTH = 16,
    parameter int TOP_MAX     = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [chs_pkg::TOPC_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic                              i_s_kind,
    input  chs_pkg::t_sts                     i_sts,
    output chs_pkg::t_cmd                     o_cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_raddr,
    output logic [$clog2(TABLE_DEPTH)-1:0]    o_waddr
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int SW = $clog2(TOP_MAX + 1);
    localparam int CW = (NW > SW) ? NW : SW;

    chs_pkg::t_state r_state, n_state;
    logic [chs_pkg::TOPC_W-1:0] r_top;
    logic [NW-1:0] r_n, n_n;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_idx, n_idx;
    logic          r_final, n_final;
    logic [CW-1:0] shown;
    logic [CW-1:0] n_ext;
    logic          accept;

    assign n_ext  = CW'(r_n);
    assign shown  = (32'(r_top) > TOP_MAX) ? CW'(TOP_MAX) : CW'(r_top);
    assign accept = i_s_tvalid && (r_state == chs_pkg::ST_IDLE);
    assign o_s_tready = (r_state == chs_pkg::ST_IDLE);

    // Configuration register and state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top   <= chs_pkg::TOPC_RESET;
            r_state <= chs_pkg::ST_IDLE;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_idx   <= '0;
            r_final <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_top <= i_cfg_wdata;
            end
            r_state <= n_state;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_idx   <= n_idx;
            r_final <= n_final;
        end
    end

    // Next state and commands.
    always_comb begin
        n_state = r_state;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_idx   = r_idx;
        n_final = r_final;
        o_cmd   = '0;
        o_cmd.wr_sel = chs_pkg::WR_CUR;
        o_raddr = '0;
        o_waddr = '0;
        case (r_state)
            chs_pkg::ST_IDLE: begin
                if (accept) begin
                    o_cmd.in_load = 1'b1;
                    if (i_s_kind == chs_pkg::KIND_IN_ADD) begin
                        o_cmd.add_total = 1'b1;
                        n_idx   = '0;
                        n_state = chs_pkg::ST_ADD_RD;
                    end else begin
                        o_cmd.rest_clr = 1'b1;
                        n_i     = '0;
                        n_final = 1'b0;
                        n_state = chs_pkg::ST_SORT_I;
                    end
                end
            end
            // Linear search of the used entries for the class.
            chs_pkg::ST_ADD_RD: begin
                if (r_idx >= n_ext) begin
                    n_state = chs_pkg::ST_ADD_NEW;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    o_raddr = r_idx[AW-1:0];
                    n_state = chs_pkg::ST_ADD_CMP;
                end
            end
            chs_pkg::ST_ADD_CMP: begin
                if (i_sts.type_match) begin
                    o_cmd.ram_wr = 1'b1;
                    o_cmd.wr_sel = chs_pkg::WR_MERGE;
                    o_waddr = r_idx[AW-1:0];
                    n_state = chs_pkg::ST_IDLE;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = chs_pkg::ST_ADD_RD;
                end
            end
            chs_pkg::ST_ADD_NEW: begin
                if (32'(r_n) < TABLE_DEPTH) begin
                    o_cmd.ram_wr = 1'b1;
                    o_cmd.wr_sel = chs_pkg::WR_NEW;
                    o_waddr = r_n[AW-1:0];
                    n_n = r_n + 1'b1;
                end else begin
                    o_cmd.set_ovf = 1'b1;
                end
                n_state = chs_pkg::ST_IDLE;
            end
            // Exchange sort: position i is held in a register while j sweeps.
            chs_pkg::ST_SORT_I: begin
                if (r_i >= n_ext) begin
                    n_idx   = shown;
                    n_state = chs_pkg::ST_REST_RD;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    o_raddr = r_i[AW-1:0];
                    n_j     = r_i + 1'b1;
                    n_state = chs_pkg::ST_SORT_LDI;
                end
            end
            chs_pkg::ST_SORT_LDI: begin
                o_cmd.cur_load = 1'b1;
                n_state = chs_pkg::ST_SORT_J;
            end
            chs_pkg::ST_SORT_J: begin
                if (r_j >= n_ext) begin
                    o_cmd.ram_wr = 1'b1;
                    o_cmd.wr_sel = chs_pkg::WR_CUR;
                    o_waddr = r_i[AW-1:0];
                    n_i     = r_i + 1'b1;
                    n_state = chs_pkg::ST_SORT_I;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    o_raddr = r_j[AW-1:0];
                    n_state = chs_pkg::ST_SORT_CMP;
                end
            end
            chs_pkg::ST_SORT_CMP: begin
                if (i_sts.count_gt) begin
                    o_cmd.ram_wr   = 1'b1;
                    o_cmd.wr_sel   = chs_pkg::WR_CUR;
                    o_waddr        = r_j[AW-1:0];
                    o_cmd.cur_load = 1'b1;
                end
                n_j     = r_j + 1'b1;
                n_state = chs_pkg::ST_SORT_J;
            end
            // Sum the counts of the entries below the shown ones.
            chs_pkg::ST_REST_RD: begin
                if (r_idx >= n_ext) begin
                    n_idx   = '0;
                    n_state = chs_pkg::ST_EMIT;
                end else begin
                    o_cmd.ram_rd = 1'b1;
                    o_raddr = r_idx[AW-1:0];
                    n_state = chs_pkg::ST_REST_ADD;
                end
            end
            chs_pkg::ST_REST_ADD: begin
                o_cmd.rest_add = 1'b1;
                n_idx   = r_idx + 1'b1;
                n_state = chs_pkg::ST_REST_RD;
            end
            // Emit ranked slots, empty slots and the remainder.
            chs_pkg::ST_EMIT: begin
                if (r_idx >= shown) begin
                    o_cmd.div_start = 1'b1;
                    o_cmd.div_rest  = 1'b1;
                    n_final = 1'b1;
                    n_state = chs_pkg::ST_DIV;
                end else if (r_idx < n_ext) begin
                    o_cmd.ram_rd = 1'b1;
                    o_raddr = r_idx[AW-1:0];
                    n_state = chs_pkg::ST_EMIT_DAT;
                end else begin
                    o_cmd.slot_empty = 1'b1;
                    n_state = chs_pkg::ST_OUT;
                end
            end
            chs_pkg::ST_EMIT_DAT: begin
                o_cmd.div_start = 1'b1;
                n_state = chs_pkg::ST_DIV;
            end
            chs_pkg::ST_DIV: begin
                if (i_sts.div_ok) begin
                    n_state = chs_pkg::ST_OUT;
                end
            end
            chs_pkg::ST_OUT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (r_final) begin
                        o_cmd.report_end = 1'b1;
                        n_n     = '0;
                        n_state = chs_pkg::ST_IDLE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = chs_pkg::ST_EMIT;
                    end
                end
            end
            default: begin
                n_state = chs_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/chs_dp.sv */
// Datapath of the class histogram share block: totals, sort register, divider, output beat.
module chs_dp #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  chs_pkg::t_cmd                       i_cmd,
    output chs_pkg::t_sts                       o_sts,
    input  logic [chs_pkg::TYPE_W-1:0]          i_s_type,
    input  logic [chs_pkg::PIX_W-1:0]           i_s_pix,
    input  logic [chs_pkg::ENTRY_W-1:0]         i_ram_rdata,
    output logic [chs_pkg::ENTRY_W-1:0]         o_ram_wdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    output logic [chs_pkg::KIND_W-1:0]          o_m_kind,
    output logic [chs_pkg::TYPE_W-1:0]          o_m_type,
    output logic [chs_pkg::SHARE_W-1:0]         o_m_share,
    output logic                                o_m_ovf,
    output logic                                o_m_last
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int RW = chs_pkg::CNT_W + AW;
    localparam int CW = chs_pkg::CNT_W;
    localparam int SH = chs_pkg::SHARE_W;
    localparam int DCW = $clog2(SH + 1);

    logic [chs_pkg::TYPE_W-1:0] r_in_type;
    logic [chs_pkg::PIX_W-1:0]  r_in_pix;
    logic [CW-1:0]              r_total;
    logic                       r_ovf;
    logic [chs_pkg::ENTRY_W-1:0] r_cur;
    logic [RW-1:0]              r_rest;
    logic [chs_pkg::PROD_W-1:0] r_prod;
    logic                       r_mul_pend;
    logic                       r_div_run;
    logic [DCW-1:0]             r_dcnt;
    logic [CW-1:0]              r_rem;
    logic [SH-1:0]              r_q;
    logic                       r_div_ok;
    logic [chs_pkg::KIND_W-1:0] r_res_kind;
    logic [chs_pkg::TYPE_W-1:0] r_res_type;
    logic                       r_ovalid;
    logic [chs_pkg::KIND_W-1:0] r_okind;
    logic [chs_pkg::TYPE_W-1:0] r_otype;
    logic [SH-1:0]              r_oshare;
    logic                       r_oovf;
    logic                       r_olast;

    logic [chs_pkg::TYPE_W-1:0] ram_type;
    logic [CW-1:0]              ram_count;
    logic [CW:0]                merge_sum;
    logic [CW-1:0]              merge_sat;
    logic [CW:0]                total_sum;
    logic [RW-1:0]              div_val;
    logic [CW:0]                step_t;
    logic [CW:0]                step_d;
    logic                       step_ge;
    logic                       out_free;

    assign ram_type  = i_ram_rdata[chs_pkg::ENTRY_W-1:CW];
    assign ram_count = i_ram_rdata[CW-1:0];
    assign merge_sum = {1'b0, ram_count} + (CW+1)'(r_in_pix);
    assign merge_sat = merge_sum[CW] ? '1 : merge_sum[CW-1:0];
    assign total_sum = {1'b0, r_total} + (CW+1)'(i_s_pix);
    assign div_val   = i_cmd.div_rest ? r_rest : RW'(ram_count);
    assign step_t    = {r_rem, r_prod[SH-1]};
    assign step_d    = step_t - {1'b0, r_total};
    assign step_ge   = step_t >= {1'b0, r_total};
    assign out_free  = !r_ovalid || i_m_tready;

    // Table write data.
    always_comb begin
        case (i_cmd.wr_sel)
            chs_pkg::WR_MERGE: o_ram_wdata = {r_in_type, merge_sat};
            chs_pkg::WR_NEW:   o_ram_wdata = {r_in_type, CW'(r_in_pix)};
            default:           o_ram_wdata = r_cur;
        endcase
    end

    assign o_sts.type_match = (ram_type == r_in_type);
    assign o_sts.count_gt   = (ram_count > r_cur[CW-1:0]);
    assign o_sts.div_ok     = r_div_ok;
    assign o_sts.out_free   = out_free;

    // Running total and sticky overflow flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_total <= '0;
            r_ovf   <= 1'b0;
        end else begin
            if (i_cmd.add_total) begin
                r_total <= total_sum[CW] ? '1 : total_sum[CW-1:0];
            end else if (i_cmd.report_end) begin
                r_total <= '0;
            end
            if (i_cmd.set_ovf) begin
                r_ovf <= 1'b1;
            end
        end
    end

    // Input item, sort holding register and remainder sum.
    always_ff @(posedge i_clk) begin
        if (i_cmd.in_load) begin
            r_in_type <= i_s_type;
            r_in_pix  <= i_s_pix;
        end
        if (i_cmd.cur_load) begin
            r_cur <= i_ram_rdata;
        end
        if (i_cmd.rest_clr) begin
            r_rest <= '0;
        end else if (i_cmd.rest_add) begin
            r_rest <= r_rest + RW'(ram_count);
        end
        if (i_cmd.div_start) begin
            r_res_kind <= i_cmd.div_rest ? chs_pkg::KIND_REST : chs_pkg::KIND_RANKED;
            r_res_type <= ram_type;
        end else if (i_cmd.slot_empty) begin
            r_res_kind <= chs_pkg::KIND_EMPTY;
        end
    end

    // Share divider: one multiply, then one restoring quotient bit per cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_pend <= 1'b0;
            r_div_run  <= 1'b0;
            r_div_ok   <= 1'b0;
            r_dcnt     <= '0;
        end else if (i_cmd.div_start) begin
            r_div_ok   <= 1'b0;
            r_mul_pend <= 1'b0;
            r_div_run  <= 1'b0;
            if (r_total == '0) begin
                r_q      <= '0;
                r_div_ok <= 1'b1;
            end else if (div_val >= RW'(r_total)) begin
                r_q      <= SH'(chs_pkg::FULL_SHARE);
                r_div_ok <= 1'b1;
            end else begin
                r_prod     <= div_val[CW-1:0] * chs_pkg::PROD_W'(chs_pkg::FULL_SHARE);
                r_mul_pend <= 1'b1;
            end
        end else if (r_mul_pend) begin
            r_mul_pend <= 1'b0;
            r_rem      <= r_prod[chs_pkg::PROD_W-1:SH];
            r_dcnt     <= DCW'(SH);
            r_div_run  <= 1'b1;
        end else if (r_div_run) begin
            r_rem  <= step_ge ? step_d[CW-1:0] : step_t[CW-1:0];
            r_prod <= {r_prod[chs_pkg::PROD_W-2:0], step_ge};
            r_dcnt <= r_dcnt - 1'b1;
            if (r_dcnt == DCW'(1)) begin
                r_div_run <= 1'b0;
                r_div_ok  <= 1'b1;
                r_q       <= {r_prod[SH-2:0], step_ge};
            end
        end
    end

    // Output beat register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_ovalid <= 1'b1;
        end else if (i_m_tready) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_okind  <= r_res_kind;
            r_otype  <= (r_res_kind == chs_pkg::KIND_RANKED) ? r_res_type : '0;
            r_oshare <= (r_res_kind == chs_pkg::KIND_EMPTY) ? '0 : r_q;
            r_oovf   <= r_ovf;
            r_olast  <= (r_res_kind == chs_pkg::KIND_REST);
        end
    end

    assign o_m_tvalid = r_ovalid;
    assign o_m_kind   = r_okind;
    assign o_m_type   = r_otype;
    assign o_m_share  = r_oshare;
    assign o_m_ovf    = r_oovf;
    assign o_m_last   = r_olast;

endmodule

/* rtl/class_histogram_top_share_unit.sv */
// Top level of the class histogram share block.
//
// Input stream: s_tdata holds class_type and pixel_count, s_tuser the kind
// (add or report). An add beat merges its count into the class table by a
// linear search of the used entries, and appends a new class at the end of
// the table or sets the sticky overflow flag when the table is full. A
// report beat sorts the table with an exchange sort (one table RAM port each
// for read and write), sums the entries past the shown ones, then emits
// top_count slots, capped at TOP_MAX, ranked or empty, and one remainder
// beat marked by m_tlast. Each share goes through a multiply and the
// shift-subtract divider, or is set directly when the total is zero or the
// count reaches it. The block takes one item at a time: s_tready is high
// only while no item is in work. The output beat register holds a result
// while m_tready is low and the controller waits for it. Synchronous reset
// empties the table, clears the total and the overflow flag and loads
// top_count with 5; there is no clearing pass. The configuration write
// takes effect at the next edge.
module class_histogram_top_share_unit #(
    parameter int TABLE_DEPTH = 16,
    parameter int TOP_MAX     = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata,     // top_count
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,         // class_type[15:0], pixel_count[39:16]
    input  logic        s_tuser,         // kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,         // result_type[15:0], share_hundredths[29:16]
    output logic [2:0]  m_tuser,         // entry_kind[1:0], overflow_seen[2]
    output logic        m_tlast          // last_of_report
);

    localparam int AW = $clog2(TABLE_DEPTH);

    chs_pkg::t_cmd cmd;
    chs_pkg::t_sts sts;
    logic [AW-1:0] raddr;
    logic [AW-1:0] waddr;
    logic [chs_pkg::ENTRY_W-1:0] ram_rdata;
    logic [chs_pkg::ENTRY_W-1:0] ram_wdata;
    logic [chs_pkg::KIND_W-1:0]  m_kind;
    logic [chs_pkg::TYPE_W-1:0]  m_type;
    logic [chs_pkg::SHARE_W-1:0] m_share;
    logic                        m_ovf;

    chs_ctrl #(
        .TABLE_DEPTH(TABLE_DEPTH),
        .TOP_MAX    (TOP_MAX)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_kind   (s_tuser),
        .i_sts      (sts),
        .o_cmd      (cmd),
        .o_raddr    (raddr),
        .o_waddr    (waddr)
    );

    chs_ram #(
        .WIDTH(chs_pkg::ENTRY_W),
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (cmd.ram_wr),
        .i_waddr(waddr),
        .i_wdata(ram_wdata),
        .i_re   (cmd.ram_rd),
        .i_raddr(raddr),
        .o_rdata(ram_rdata)
    );

    chs_dp #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .i_s_type   (s_tdata[15:0]),
        .i_s_pix    (s_tdata[39:16]),
        .i_ram_rdata(ram_rdata),
        .o_ram_wdata(ram_wdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_kind   (m_kind),
        .o_m_type   (m_type),
        .o_m_share  (m_share),
        .o_m_ovf    (m_ovf),
        .o_m_last   (m_tlast)
    );

    assign m_tdata = {2'b00, m_share, m_type};
    assign m_tuser = {m_ovf, m_kind};

endmodule
